[rtl/core/iar_pkg.sv]
// Shared types, conversion codes and character constants for the integer to ASCII block.
package iar_pkg;

  localparam int MAX_CHARS = 11;

  localparam logic [2:0] FUNC_SDEC  = 3'd0;
  localparam logic [2:0] FUNC_UDEC  = 3'd1;
  localparam logic [2:0] FUNC_HEXL  = 3'd2;
  localparam logic [2:0] FUNC_HEXU  = 3'd3;
  localparam logic [2:0] FUNC_OCT   = 3'd4;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_LOWA  = 8'h61;
  localparam logic [7:0] ASCII_UPA   = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;

  // Reciprocal of ten, scaled by two to the power 35.
  localparam logic [31:0] RECIP10 = 32'hcccc_cccd;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } iar_cmd_t;

  typedef struct packed {
    logic func_ok;
    logic conv_done;
    logic out_free;
    logic emit_last;
  } iar_status_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'b0, d};
    end else if (upper) begin
      c = ASCII_UPA + {4'b0, d} - 8'd10;
    end else begin
      c = ASCII_LOWA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[rtl/core/iar_in_if.sv]
// Input channel interface: one value and its conversion code.
interface iar_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  func;

  modport source (output valid, output value, output func, input ready);
  modport sink (input valid, input value, input func, output ready);
endinterface

[rtl/core/iar_out_if.sv]
// Output channel interface: one ASCII character with its end marker and count.
interface iar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic [3:0] char_count;

  modport source (output valid, output character, output last, output char_count, input ready);
  modport sink (input valid, input character, input last, input char_count, output ready);
endinterface

[rtl/core/integer_to_ascii_radix.sv]
// Top level of the integer to ASCII converter for signed, unsigned, hex and octal output.
// Each transaction on item carries a 32-bit value and a conversion code (signed decimal,
// unsigned decimal, lower- or upper-case hex, octal); undefined codes are taken and dropped.
// The block answers with one transaction on result per character, most significant first,
// with '-' ahead of a negative signed decimal and last with the character count on the final
// one. A number is accepted, its digits are extracted in the divide-by-radix step (a reciprocal
// multiply for decimal), and its characters then leave through the output register, which
// waits while result is stalled. That register lets the next value be accepted while the
// final character waits.
module integer_to_ascii_radix
  import iar_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  iar_in_if.sink    item,
  iar_out_if.source result
);

  iar_cmd_t    cmd;
  iar_status_t status;
  logic        ready;

  assign item.ready = ready;

  iar_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  iar_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .value  (item.value),
    .func   (item.func),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

[rtl/core/iar_datapath.sv]
// Datapath: magnitude register, digit extraction, digit buffer and output register.
module iar_datapath
  import iar_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   value,
  input  logic [2:0]    func,
  input  iar_cmd_t      cmd,
  output iar_status_t   status,
  iar_out_if.source     result
);

  logic [31:0] mag;
  logic [2:0]  func_reg;
  logic        neg;
  logic [3:0]  ndig;
  logic [3:0]  pos;
  logic [3:0]  digits [MAX_CHARS];

  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;
  logic [3:0]  out_count;

  logic [63:0] prod;
  logic [31:0] q_dec;
  logic [31:0] r_dec;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [3:0]  total;
  logic [3:0]  idx;
  logic        is_last;
  logic        upper;
  logic [7:0]  next_char;

  // Decimal digits come from a reciprocal multiply that is exact for every 32-bit value.
  assign prod  = {32'b0, mag} * {32'b0, RECIP10};
  assign q_dec = {3'b0, prod[63:35]};
  assign r_dec = mag - (q_dec << 3) - (q_dec << 1);

  always_comb begin
    unique case (func_reg) inside
      FUNC_HEXL, FUNC_HEXU: begin
        quot = mag >> 4;
        rem  = mag[3:0];
      end
      FUNC_OCT: begin
        quot = mag >> 3;
        rem  = {1'b0, mag[2:0]};
      end
      default: begin
        quot = q_dec;
        rem  = r_dec[3:0];
      end
    endcase
  end

  assign upper     = (func_reg == FUNC_HEXU);
  assign total     = ndig + {3'b0, neg};
  // Digits were stored least significant first, so they are read back from the top.
  assign idx       = ndig - 4'd1 - pos + {3'b0, neg};
  assign is_last   = (pos == total - 4'd1);
  assign next_char = (neg && pos == 4'd0) ? ASCII_MINUS : digit_to_ascii(digits[idx], upper);

  assign status.func_ok   = (func == FUNC_SDEC) || (func == FUNC_UDEC) || (func == FUNC_HEXL) ||
                            (func == FUNC_HEXU) || (func == FUNC_OCT);
  assign status.conv_done = (quot == 32'd0) || (ndig == 4'(MAX_CHARS - 1));
  assign status.out_free  = !out_valid || result.ready;
  assign status.emit_last = is_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_reg <= func;
      if (func == FUNC_SDEC && value[31]) begin
        neg <= 1'b1;
        mag <= 32'd0 - value;
      end else begin
        neg <= 1'b0;
        mag <= value;
      end
      ndig <= 4'd0;
      pos  <= 4'd0;
    end
    if (cmd.step) begin
      digits[ndig] <= rem;
      ndig         <= ndig + 4'd1;
      mag          <= quot;
    end
    if (cmd.emit) begin
      out_char  <= next_char;
      out_last  <= is_last;
      out_count <= is_last ? total : 4'd0;
      pos       <= pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid      = out_valid;
  assign result.character  = out_char;
  assign result.last       = out_last;
  assign result.char_count = out_count;

endmodule

[rtl/core/iar_controller.sv]
// Controller: sequences loading, digit extraction and character emission.
module iar_controller
  import iar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  iar_status_t status,
  output iar_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE    = 3'b001,
    CONVERT = 3'b010,
    EMIT    = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        // An undefined conversion code is taken and dropped.
        if (in_valid && status.func_ok) begin
          cmd.load   = 1'b1;
          state_next = CONVERT;
        end
      end
      CONVERT: begin
        cmd.step = 1'b1;
        if (status.conv_done) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
